### rtl/core/periodic_beep_burst_sequencer_defines.svh
// Assertion macros shared by the beep burst sequencer RTL.
`ifndef PERIODIC_BEEP_BURST_SEQUENCER_DEFINES_SVH
`define PERIODIC_BEEP_BURST_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PBBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pbbs_pkg.sv
// Types, register codes and reset values for the beep burst sequencer.
`default_nettype none
package pbbs_pkg;

    localparam int TimeW  = 32;
    localparam int MsW    = 16;
    localparam int CountW = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_PERIOD_MS  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ON_MS      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OFF_MS     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BEEP_COUNT = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TONE_VALUE = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CTRL_VALUE = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_STARTUP_MS = 3'd6;

    // reset values
    localparam logic [MsW-1:0]    RST_PERIOD_MS  = 16'd2000;
    localparam logic [MsW-1:0]    RST_ON_MS      = 16'd100;
    localparam logic [MsW-1:0]    RST_OFF_MS     = 16'd100;
    localparam logic [CountW-1:0] RST_BEEP_COUNT = 8'd0;
    localparam logic [MsW-1:0]    RST_TONE_VALUE = 16'd0;
    localparam logic [MsW-1:0]    RST_CTRL_VALUE = 16'd0;
    localparam logic [MsW-1:0]    RST_STARTUP_MS = 16'd3000;

    typedef struct packed {
        logic [MsW-1:0]    period_ms;
        logic [MsW-1:0]    on_ms;
        logic [MsW-1:0]    off_ms;
        logic [CountW-1:0] beep_count;
        logic [MsW-1:0]    tone_value;
        logic [MsW-1:0]    ctrl_value;
        logic [MsW-1:0]    startup_ms;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0]  period_start;
        logic [TimeW-1:0]  phase_start;
        logic [CountW-1:0] remaining;
        logic              sounding;
    } t_state;

    // what the step logic decided for one poll
    typedef struct packed {
        logic armed;      // startup guard passed
        logic reload;     // period elapsed, count reloaded
        logic beep_done;  // one beep finished, count decremented
    } t_step_flags;

endpackage
`default_nettype wire

### rtl/core/pbbs_if.sv
// Stream and configuration channel interfaces of the beep burst sequencer.
`default_nettype none
interface pbbs_in_if;
    logic                      valid;
    logic                      ready;
    logic [pbbs_pkg::TimeW-1:0] now_ms;
    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface pbbs_out_if;
    logic                     valid;
    logic                     ready;
    logic [pbbs_pkg::MsW-1:0] tone_out;
    logic [pbbs_pkg::MsW-1:0] ctrl_out;
    logic                     red_led;
    modport source (output valid, output tone_out, output ctrl_out, output red_led,
                    input ready);
    modport sink   (input valid, input tone_out, input ctrl_out, input red_led,
                    output ready);
endinterface

interface pbbs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pbbs_pkg::CfgIdxW-1:0]  index;
    logic [pbbs_pkg::CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/pbbs_step.sv
// Next-state and result logic for one poll of the beep burst sequencer.
`default_nettype none
module pbbs_step (
    input  wire logic [pbbs_pkg::TimeW-1:0] i_now_ms,
    input  wire pbbs_pkg::t_cfg             i_cfg,
    input  wire pbbs_pkg::t_state           i_state,
    output pbbs_pkg::t_state                o_next_state,
    output pbbs_pkg::t_step_flags           o_flags,
    output logic [pbbs_pkg::MsW-1:0]        o_tone_out,
    output logic [pbbs_pkg::MsW-1:0]        o_ctrl_out,
    output logic                            o_red_led
);

    logic [pbbs_pkg::TimeW-1:0] since_period;
    logic [pbbs_pkg::TimeW-1:0] since_phase;
    logic [pbbs_pkg::MsW:0]     beep_window;
    logic                       armed;
    logic                       period_over;
    logic                       in_on;
    logic                       in_off;

    // wrapping time differences and window compares
    assign since_period = i_now_ms - i_state.period_start;
    assign since_phase  = i_now_ms - i_state.phase_start;
    assign beep_window  = {1'b0, i_cfg.on_ms} + {1'b0, i_cfg.off_ms};
    assign armed        = i_now_ms >= {{(pbbs_pkg::TimeW-pbbs_pkg::MsW){1'b0}},
                                       i_cfg.startup_ms};
    assign period_over  = since_period > {{(pbbs_pkg::TimeW-pbbs_pkg::MsW){1'b0}},
                                          i_cfg.period_ms};
    assign in_on        = since_phase < {{(pbbs_pkg::TimeW-pbbs_pkg::MsW){1'b0}},
                                         i_cfg.on_ms};
    assign in_off       = since_phase < {{(pbbs_pkg::TimeW-pbbs_pkg::MsW-1){1'b0}},
                                         beep_window};

    // advance the burst sequence
    always_comb begin
        o_next_state = i_state;
        o_flags      = '0;
        o_flags.armed = armed;
        if (armed) begin
            priority if (period_over) begin
                o_next_state.remaining    = i_cfg.beep_count;
                o_next_state.period_start = i_now_ms;
                o_next_state.phase_start  = i_now_ms;
                o_flags.reload            = 1'b1;
            end else if (i_state.remaining != '0) begin
                priority if (in_on) begin
                    o_next_state.sounding = 1'b1;
                end else if (in_off) begin
                    o_next_state.sounding = 1'b0;
                end else begin
                    o_next_state.remaining   = i_state.remaining - 1'b1;
                    o_next_state.phase_start = i_now_ms;
                    o_flags.beep_done        = 1'b1;
                end
            end
        end
    end

    // drive the beeper words from the updated sounding bit
    assign o_tone_out = o_next_state.sounding ? i_cfg.tone_value : '0;
    assign o_ctrl_out = o_next_state.sounding ? i_cfg.ctrl_value : '0;
    assign o_red_led  = o_next_state.sounding;

endmodule
`default_nettype wire

### rtl/core/periodic_beep_burst_sequencer.sv
// Top level of the periodic beep burst sequencer: registers, handshakes, checks.
//
//  channel | dir | payload                       | beat taken when
//  i_in    | in  | now_ms[31:0]                  | valid && ready
//  o_out   | out | tone_out, ctrl_out, red_led   | valid && ready
//  i_cfg   | in  | index[2:0], data[15:0]        | valid && ready (ready is always high)
//
// One poll beat per cycle is accepted while the result is not stalled; each beat yields
// one result. The poll sits in an input register, the step logic updates state and
// fills the result register. Input ready drops only while both registers are full
// and the result is stalled. Reset (i_rst_n low, synchronous) clears the timers,
// the count and the sounding bit, and restores the register defaults.
`default_nettype none
`include "periodic_beep_burst_sequencer_defines.svh"
module periodic_beep_burst_sequencer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pbbs_in_if.sink      i_in,
    pbbs_out_if.source   o_out,
    pbbs_cfg_if.sink     i_cfg
);

    pbbs_pkg::t_cfg        r_cfg;
    pbbs_pkg::t_state      r_state;
    pbbs_pkg::t_state      n_state;
    pbbs_pkg::t_step_flags step_flags;

    logic                        r_in_valid;
    logic [pbbs_pkg::TimeW-1:0]  r_now_ms;
    logic                        r_out_valid;
    logic [pbbs_pkg::MsW-1:0]    r_tone_out;
    logic [pbbs_pkg::MsW-1:0]    r_ctrl_out;
    logic                        r_red_led;
    logic [pbbs_pkg::MsW-1:0]    n_tone_out;
    logic [pbbs_pkg::MsW-1:0]    n_ctrl_out;
    logic                        n_red_led;
    logic                        advance;
    logic                        in_beat;
    logic                        out_beat;

    // handshakes
    assign out_beat    = r_out_valid && o_out.ready;
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_beat     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ms  <= pbbs_pkg::RST_PERIOD_MS;
            r_cfg.on_ms      <= pbbs_pkg::RST_ON_MS;
            r_cfg.off_ms     <= pbbs_pkg::RST_OFF_MS;
            r_cfg.beep_count <= pbbs_pkg::RST_BEEP_COUNT;
            r_cfg.tone_value <= pbbs_pkg::RST_TONE_VALUE;
            r_cfg.ctrl_value <= pbbs_pkg::RST_CTRL_VALUE;
            r_cfg.startup_ms <= pbbs_pkg::RST_STARTUP_MS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pbbs_pkg::REG_PERIOD_MS:  r_cfg.period_ms  <= i_cfg.data;
                pbbs_pkg::REG_ON_MS:      r_cfg.on_ms      <= i_cfg.data;
                pbbs_pkg::REG_OFF_MS:     r_cfg.off_ms     <= i_cfg.data;
                pbbs_pkg::REG_BEEP_COUNT: r_cfg.beep_count <= i_cfg.data[pbbs_pkg::CountW-1:0];
                pbbs_pkg::REG_TONE_VALUE: r_cfg.tone_value <= i_cfg.data;
                pbbs_pkg::REG_CTRL_VALUE: r_cfg.ctrl_value <= i_cfg.data;
                pbbs_pkg::REG_STARTUP_MS: r_cfg.startup_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register: hold the poll until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_now_ms <= i_in.now_ms;
        end
    end

    pbbs_step u_step (
        .i_now_ms     (r_now_ms),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_flags      (step_flags),
        .o_tone_out   (n_tone_out),
        .o_ctrl_out   (n_ctrl_out),
        .o_red_led    (n_red_led)
    );

    // sequence state: update once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tone_out <= n_tone_out;
            r_ctrl_out <= n_ctrl_out;
            r_red_led  <= n_red_led;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.tone_out = r_tone_out;
    assign o_out.ctrl_out = r_ctrl_out;
    assign o_out.red_led  = r_red_led;

    // checks
    `PBBS_ASSERT_NOW(a_silent_words, i_clk, i_rst_n, r_out_valid && !r_red_led, r_tone_out == '0 && r_ctrl_out == '0, "beeper words nonzero while LED off")
    `PBBS_ASSERT_NEXT(a_guard_holds, i_clk, i_rst_n, advance && !step_flags.armed, $stable(r_state), "state changed before startup guard elapsed")
    `PBBS_ASSERT_NEXT(a_period_reload, i_clk, i_rst_n, advance && step_flags.reload, r_state.remaining == $past(r_cfg.beep_count) && r_state.period_start == $past(r_now_ms), "period reload did not restart the burst")
    `PBBS_ASSERT_NEXT(a_count_drops, i_clk, i_rst_n, advance && step_flags.beep_done, r_state.remaining == $past(r_state.remaining) - 1'b1 && r_state.phase_start == $past(r_now_ms), "beep end did not decrement count and restart phase")
    `PBBS_ASSERT_NEXT(a_no_loss, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_now_ms), "stalled poll dropped")

endmodule
`default_nettype wire

### tb/periodic_beep_burst_sequencer_tb.sv
// Self-checking testbench for the periodic beep burst sequencer: poll stream, results, registers.
module periodic_beep_burst_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pbbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_POLLS = 950;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

    typedef enum int {PROF_TYPICAL, PROF_EXTREME, PROF_NOISE} t_profile;

    typedef struct packed {
        logic [MsW-1:0] tone_out;
        logic [MsW-1:0] ctrl_out;
        logic           red_led;
    } t_beep;

    // Mirror of the sequencer: register copy, timers, count, and the beeper outputs due
    class beep_scoreboard;
        t_cfg              regs;
        logic [TimeW-1:0]  period_start;
        logic [TimeW-1:0]  phase_start;
        logic [CountW-1:0] remaining;
        logic              sounding;
        t_beep             beeps_due[$];
        int unsigned       errors;

        function new();
            regs.period_ms  = RST_PERIOD_MS;
            regs.on_ms      = RST_ON_MS;
            regs.off_ms     = RST_OFF_MS;
            regs.beep_count = RST_BEEP_COUNT;
            regs.tone_value = RST_TONE_VALUE;
            regs.ctrl_value = RST_CTRL_VALUE;
            regs.startup_ms = RST_STARTUP_MS;
            period_start = '0;
            phase_start  = '0;
            remaining    = '0;
            sounding     = 1'b0;
            errors       = 0;
        endfunction

        // Track a register write; unknown indexes are dropped
        function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
            case (idx)
                REG_PERIOD_MS:  regs.period_ms  = data;
                REG_ON_MS:      regs.on_ms      = data;
                REG_OFF_MS:     regs.off_ms     = data;
                REG_BEEP_COUNT: regs.beep_count = data[CountW-1:0];
                REG_TONE_VALUE: regs.tone_value = data;
                REG_CTRL_VALUE: regs.ctrl_value = data;
                REG_STARTUP_MS: regs.startup_ms = data;
                default: ;
            endcase
        endfunction

        // Step the sequencer for one poll and queue the outputs it shows
        function void take_poll(input logic [TimeW-1:0] now);
            logic [TimeW-1:0] since_period;
            logic [TimeW-1:0] since_phase;
            logic [TimeW-1:0] on_win;
            logic [TimeW-1:0] beep_win;
            t_beep            b;
            on_win   = {16'd0, regs.on_ms};
            beep_win = {16'd0, regs.on_ms} + {16'd0, regs.off_ms};
            if (now >= {16'd0, regs.startup_ms}) begin
                since_period = now - period_start;
                if (since_period > {16'd0, regs.period_ms}) begin
                    remaining    = regs.beep_count;
                    period_start = now;
                    phase_start  = now;
                end else if (remaining != '0) begin
                    since_phase = now - phase_start;
                    if (since_phase < on_win) begin
                        sounding = 1'b1;
                    end else if (since_phase < beep_win) begin
                        sounding = 1'b0;
                    end else begin
                        remaining   = remaining - 1'b1;
                        phase_start = now;
                    end
                end
            end
            b.tone_out = sounding ? regs.tone_value : '0;
            b.ctrl_out = sounding ? regs.ctrl_value : '0;
            b.red_led  = sounding;
            beeps_due.push_back(b);
        endfunction

        // Compare one result beat against the oldest expected outputs
        function void check_beep(input t_beep got);
            t_beep want;
            if (beeps_due.size() == 0) begin
                $error("result beat with nothing expected: tone %h ctrl %h led %b",
                       got.tone_out, got.ctrl_out, got.red_led);
                errors++;
                return;
            end
            want = beeps_due.pop_front();
            if (got.tone_out !== want.tone_out) begin
                $error("tone_out: expected %h, actual %h", want.tone_out, got.tone_out);
                errors++;
            end
            if (got.ctrl_out !== want.ctrl_out) begin
                $error("ctrl_out: expected %h, actual %h", want.ctrl_out, got.ctrl_out);
                errors++;
            end
            if (got.red_led !== want.red_led) begin
                $error("red_led: expected %b, actual %b", want.red_led, got.red_led);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return beeps_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          no_idle = 1'b0;
    int unsigned cycles = 0;
    beep_scoreboard board;

    pbbs_in_if  in_if ();
    pbbs_out_if out_if ();
    pbbs_cfg_if cfg_if ();

    periodic_beep_burst_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one poll after a random gap and hold it until the beat is taken
    task automatic send_poll(input logic [TimeW-1:0] now);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.now_ms <= now;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.take_poll(now);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Let the block go idle, then load a full register set
    task automatic apply_settings(input t_cfg s);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        cfg_write(REG_PERIOD_MS, s.period_ms);
        cfg_write(REG_ON_MS, s.on_ms);
        cfg_write(REG_OFF_MS, s.off_ms);
        // upper data bits must be dropped by the count register
        cfg_write(REG_BEEP_COUNT, {8'($urandom), s.beep_count});
        cfg_write(REG_TONE_VALUE, s.tone_value);
        cfg_write(REG_CTRL_VALUE, s.ctrl_value);
        cfg_write(REG_STARTUP_MS, s.startup_ms);
        if ($urandom_range(0, 3) == 0) begin
            cfg_write(REG_UNUSED, 16'($urandom));
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [MsW-1:0] pick_ms(input t_profile prof, input int unsigned lo,
                                               input int unsigned hi);
        case (prof)
            PROF_EXTREME: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return 16'($urandom);
                endcase
            end
            PROF_NOISE: return 16'($urandom);
            default:    return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // Take result beats with random back-pressure
    initial begin
        int unsigned gap;
        t_beep       got;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            got.tone_out = out_if.tone_out;
            got.ctrl_out = out_if.ctrl_out;
            got.red_led  = out_if.red_led;
            board.check_beep(got);
        end
    end

    // Reset, directed polls, then random phases
    initial begin
        t_cfg             s;
        t_profile         prof;
        logic [TimeW-1:0] now;
        int unsigned      random_polls;
        int unsigned      phase_len;
        int unsigned      fine_step;
        int unsigned      pick;
        board = new();
        in_if.valid   <= 1'b0;
        in_if.now_ms  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: startup guard, then a reload with a zero count
        send_poll(32'd0);
        send_poll(32'd3000);

        // short windows: walk a full burst, then hold after the count runs out
        s = board.regs;
        s.period_ms  = 16'd20;
        s.on_ms      = 16'd3;
        s.off_ms     = 16'd2;
        s.beep_count = 8'd2;
        s.tone_value = 16'hFFFF;
        s.ctrl_value = 16'hA5A5;
        s.startup_ms = 16'd10;
        apply_settings(s);
        send_poll(32'd9);
        send_poll(32'd3010);
        send_poll(32'd3021);
        send_poll(32'd3022);
        send_poll(32'd3024);
        send_poll(32'd3026);
        send_poll(32'd3027);
        send_poll(32'd3030);
        send_poll(32'd3031);
        send_poll(32'd3035);
        send_poll(32'd3050);
        send_poll(32'd3050);

        // tone change while sounding, then time going backwards
        s.tone_value = 16'h1234;
        apply_settings(s);
        send_poll(32'd3051);
        send_poll(32'd3040);
        send_poll(32'd3041);

        // zero windows: each poll only burns a beep
        s.on_ms  = 16'd0;
        s.off_ms = 16'd0;
        apply_settings(s);
        send_poll(32'd3042);
        send_poll(32'd3043);

        // register extremes and the top of the time range
        s.period_ms  = '1;
        s.on_ms      = '1;
        s.off_ms     = '1;
        s.beep_count = '1;
        s.tone_value = '0;
        s.ctrl_value = '1;
        s.startup_ms = '1;
        apply_settings(s);
        send_poll(32'hFFFF_FFFF);
        send_poll(32'h0000_FFFF);
        send_poll(32'h0001_0000);
        send_poll(32'd0);
        s.period_ms  = '0;
        s.startup_ms = '0;
        apply_settings(s);
        send_poll(32'd0);
        send_poll(32'd0);

        // random phases: mostly a clock that moves through the windows, some jumps
        now = 32'd3043;
        random_polls = 0;
        while (random_polls < RANDOM_POLLS) begin
            pick = $urandom_range(0, 99);
            prof = (pick < 70) ? PROF_TYPICAL : (pick < 85) ? PROF_EXTREME : PROF_NOISE;
            s.period_ms  = pick_ms(prof, 20, 400);
            s.on_ms      = pick_ms(prof, 0, 40);
            s.off_ms     = pick_ms(prof, 0, 40);
            s.beep_count = 8'(pick_ms(prof, 0, 12));
            s.tone_value = pick_ms(prof, 0, 65535);
            s.ctrl_value = pick_ms(prof, 0, 65535);
            s.startup_ms = pick_ms(prof, 0, 3000);
            apply_settings(s);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            fine_step = (int'(s.on_ms) + int'(s.off_ms)) / 3 + 2;
            case ($urandom_range(0, 5))
                0:       now = $urandom;
                1:       now = 32'hFFFF_FFFF - $urandom_range(0, 500);
                2:       now = $urandom_range(0, int'(s.startup_ms) + 100);
                default: ;
            endcase
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    now = now + $urandom_range(0, fine_step);
                end else if (pick < 85) begin
                    now = now + $urandom_range(0, int'(s.period_ms) * 5 / 4 + 1);
                end else if (pick < 91) begin
                    now = now - $urandom_range(1, fine_step);
                end else if (pick < 96) begin
                    now = $urandom;
                end else begin
                    now = 32'hFFFF_FFFF - $urandom_range(0, fine_step);
                end
                send_poll(now);
                random_polls++;
            end
        end

        // Drain and settle
        in_if.valid <= 1'b0;
        no_idle = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
